// ===== rtl/core/assert_macros.svh =====
// assertion macros for the uart receiver rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

`define ASSERT_NEVER(lbl, prop) \
  `ASSERT(lbl, !(prop))

`else

`define ASSERT(lbl, prop)

`define ASSERT_NEVER(lbl, prop)

`endif

`endif

// ===== rtl/core/uartrx_pkg.sv =====
// shared types, constants and helpers for the uart receiver
`default_nettype none

package uartrx_pkg;

  localparam int BufferDepth = 64;
  localparam int IdxW        = $clog2(BufferDepth);
  localparam int TickW       = 16;
  localparam int DataW       = 8;
  localparam int BitIdxW     = 4;

  localparam logic [TickW-1:0] BitTicksReset = 16'd104;

  typedef logic [IdxW-1:0]  idx_t;
  typedef logic [DataW-1:0] byte_t;

  typedef enum logic [3:0] {
    PhIdle = 4'b0001,
    PhHalf = 4'b0010,
    PhData = 4'b0100,
    PhStop = 4'b1000
  } phase_e;

  typedef struct packed {
    logic  pop;
    logic  push;
    byte_t wdata;
  } rb_req_t;

  typedef struct packed {
    logic popped;
    logic dropped;
    logic avail;
  } rb_sts_t;

  function automatic idx_t rb_next(idx_t idx);
    idx_t nxt;
    if (idx == idx_t'(BufferDepth - 1)) begin
      nxt = '0;
    end else begin
      nxt = idx + 1'b1;
    end
    return nxt;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/uartrx_ring.sv =====
// receive ring buffer: pop before push, one slot kept free
`default_nettype none
`include "assert_macros.svh"

module uartrx_ring
  import uartrx_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    en_i,
  input  wire rb_req_t req_i,
  output rb_sts_t      sts_o,
  output byte_t        rdata_o
);

  byte_t mem [BufferDepth];
  byte_t rdata_q;
  idx_t  rd_q, rd_d;
  idx_t  wr_q, wr_d;
  logic  pop_ok, push_ok;

  always_comb begin
    pop_ok  = req_i.pop && (rd_q != wr_q);
    rd_d    = pop_ok ? rb_next(rd_q) : rd_q;
    push_ok = req_i.push && (rb_next(wr_q) != rd_d);
    wr_d    = push_ok ? rb_next(wr_q) : wr_q;
    sts_o.popped  = pop_ok;
    sts_o.dropped = req_i.push && !push_ok;
    sts_o.avail   = (rd_d != wr_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q <= '0;
      wr_q <= '0;
    end else if (en_i) begin
      rd_q <= rd_d;
      wr_q <= wr_d;
    end
  end

  // storage with registered read port
  always_ff @(posedge clk_i) begin
    if (en_i && push_ok) begin
      mem[wr_q] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rdata_q <= mem[rd_q];
    end
  end

  assign rdata_o = rdata_q;

  `ASSERT(rb_rd_advance, en_i && sts_o.popped |=> rd_q == rb_next($past(rd_q)))
  `ASSERT(rb_drop_full, en_i && sts_o.dropped |=> rb_next(wr_q) == rd_q)

endmodule

`default_nettype wire

// ===== rtl/core/uart_receiver_with_fifo.sv =====
// 8n1 serial receiver with receive ring buffer, top level
//
//  channel   direction  handshake                 payload
//  in        sink       in_valid_i / in_stall_o   rx_level_i, read_request_i
//  out       source     out_valid_o / out_stall_i read_data_o, read_valid_o,
//                                                 data_available_o, overflow_seen_o
//  cfg       sink       cfg_valid_i / cfg_ready_o cfg_bit_ticks_i
//
//  one tick per cycle while in_stall_o is low; each tick gives its result in the cycle after the transfer
//  the whole tick is handled between the state registers and the output register,
//  one buffer read and at most one buffer write per tick
//  in_stall_o is high only while a result waits and out_stall_i is high
//  after reset the buffer is empty, bit_ticks is 104 and the line counts as idle high
`default_nettype none
`include "assert_macros.svh"

module uart_receiver_with_fifo
  import uartrx_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic             rx_level_i,
  input  wire logic             read_request_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic [DataW-1:0]      read_data_o,
  output logic                  read_valid_o,
  output logic                  data_available_o,
  output logic                  overflow_seen_o,
  input  wire logic             cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire logic [TickW-1:0] cfg_bit_ticks_i
);

  logic [TickW-1:0]   bit_ticks_q;
  phase_e             phase_q, phase_d;
  logic [TickW-1:0]   tick_q, tick_d;
  logic [BitIdxW-1:0] bit_index_q, bit_index_d, bit_index_inc;
  byte_t              shift_q, shift_d, shift_in;
  logic               last_q;
  logic               overflow_q, overflow_d;
  logic               out_valid_q, read_valid_q, avail_q;
  logic               accept;
  logic [TickW:0]     count_inc, limit;
  logic               done;
  rb_req_t            rb_req;
  rb_sts_t            rb_sts;
  byte_t              rb_rdata;

  assign accept      = in_valid_i && !in_stall_o;
  assign in_stall_o  = out_valid_q && out_stall_i;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_ticks_q <= BitTicksReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      bit_ticks_q <= cfg_bit_ticks_i;
    end
  end

  // tick counter and frame sequencing
  always_comb begin
    count_inc     = {1'b0, tick_q} + 1'b1;
    limit         = (phase_q == PhHalf) ? {2'b00, bit_ticks_q[TickW-1:1]}
                                        : {1'b0, bit_ticks_q};
    done          = (count_inc >= limit);
    bit_index_inc = bit_index_q + 1'b1;
    shift_in      = {rx_level_i, shift_q[DataW-1:1]};
    phase_d       = phase_q;
    tick_d        = tick_q;
    bit_index_d   = bit_index_q;
    shift_d       = shift_q;
    rb_req.pop    = read_request_i;
    rb_req.push   = 1'b0;
    rb_req.wdata  = shift_in;
    case (phase_q)
      PhIdle: begin
        if (last_q && !rx_level_i) begin
          phase_d = PhHalf;
          tick_d  = '0;
        end
      end
      PhHalf: begin
        if (done) begin
          phase_d     = PhData;
          tick_d      = '0;
          bit_index_d = '0;
          shift_d     = '0;
        end else begin
          tick_d = count_inc[TickW-1:0];
        end
      end
      PhData: begin
        if (done) begin
          tick_d      = '0;
          shift_d     = shift_in;
          bit_index_d = bit_index_inc;
          if (bit_index_inc[BitIdxW-1]) begin
            rb_req.push = 1'b1;
            phase_d     = PhStop;
            bit_index_d = '0;
          end
        end else begin
          tick_d = count_inc[TickW-1:0];
        end
      end
      PhStop: begin
        if (done) begin
          phase_d = PhIdle;
          tick_d  = '0;
        end else begin
          tick_d = count_inc[TickW-1:0];
        end
      end
      default: begin
        phase_d = PhIdle;
        tick_d  = '0;
      end
    endcase
    overflow_d = overflow_q || rb_sts.dropped;
  end

  uartrx_ring u_ring (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (accept),
    .req_i   (rb_req),
    .sts_o   (rb_sts),
    .rdata_o (rb_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhIdle;
      tick_q       <= '0;
      bit_index_q  <= '0;
      shift_q      <= '0;
      last_q       <= 1'b1;
      overflow_q   <= 1'b0;
      read_valid_q <= 1'b0;
      avail_q      <= 1'b0;
    end else if (accept) begin
      phase_q      <= phase_d;
      tick_q       <= tick_d;
      bit_index_q  <= bit_index_d;
      shift_q      <= shift_d;
      last_q       <= rx_level_i;
      overflow_q   <= overflow_d;
      read_valid_q <= rb_sts.popped;
      avail_q      <= rb_sts.avail;
    end
  end

  // result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign read_data_o      = read_valid_q ? rb_rdata : byte_t'(0);
  assign read_valid_o     = read_valid_q;
  assign data_available_o = avail_q;
  assign overflow_seen_o  = overflow_q;

  `ASSERT(ovf_sticky, overflow_q |=> overflow_q)
  `ASSERT(push_only_in_data, rb_req.push |-> phase_q == PhData)
  `ASSERT_NEVER(bit_index_range, bit_index_q > 4'd7)

endmodule

`default_nettype wire

// ===== tb/uart_rx_tracker_pkg.sv =====
// tracker class predicting and checking the receiver's per-tick results
`timescale 1ns / 1ps

package uart_rx_tracker_pkg;
  import uartrx_pkg::*;

  typedef struct packed {
    byte_t data;
    logic  valid;
    logic  avail;
    logic  ovf;
  } tick_result_t;

  class rx_fifo_tracker;
    logic [TickW-1:0]   bit_ticks;
    phase_e             phase;
    logic [TickW-1:0]   tick_cnt;
    logic [BitIdxW-1:0] bit_idx;
    byte_t              shreg;
    logic               last_lvl;
    byte_t              store [BufferDepth];
    idx_t               rd_idx;
    idx_t               wr_idx;
    logic               ovf;
    tick_result_t       due [$];
    int                 errors;

    function new();
      bit_ticks = BitTicksReset;
      phase     = PhIdle;
      tick_cnt  = '0;
      bit_idx   = '0;
      shreg     = '0;
      last_lvl  = 1'b1;
      rd_idx    = '0;
      wr_idx    = '0;
      ovf       = 1'b0;
      errors    = 0;
      foreach (store[i]) store[i] = '0;
    endfunction

    function idx_t bump(idx_t i);
      return (int'(i) == BufferDepth - 1) ? idx_t'(0) : idx_t'(i + 1'b1);
    endfunction

    // one tick of a bit-time wait, true when the wait ends
    function bit count_done(int limit);
      int c;
      c = int'(tick_cnt) + 1;
      if (c >= limit) begin
        tick_cnt = '0;
        return 1'b1;
      end
      tick_cnt = c[TickW-1:0];
      return 1'b0;
    endfunction

    function int pending_count();
      return due.size();
    endfunction

    function int fill_level();
      return int'(idx_t'(wr_idx - rd_idx));
    endfunction

    function void note_tick(logic level, logic req);
      tick_result_t r;
      idx_t         nxt;
      r = '0;
      // pop comes before any store on the same tick
      if (req && rd_idx != wr_idx) begin
        r.data  = store[rd_idx];
        r.valid = 1'b1;
        rd_idx  = bump(rd_idx);
      end
      case (phase)
        PhIdle: begin
          if (last_lvl && !level) begin
            phase    = PhHalf;
            tick_cnt = '0;
          end
        end
        PhHalf: begin
          if (count_done(int'(bit_ticks >> 1))) begin
            phase   = PhData;
            bit_idx = '0;
            shreg   = '0;
          end
        end
        PhData: begin
          if (count_done(int'(bit_ticks))) begin
            shreg   = {level, shreg[7:1]};
            bit_idx = bit_idx + 1'b1;
            if (bit_idx >= 4'd8) begin
              nxt = bump(wr_idx);
              if (nxt != rd_idx) begin
                store[wr_idx] = shreg;
                wr_idx        = nxt;
              end else begin
                ovf = 1'b1;
              end
              phase   = PhStop;
              bit_idx = '0;
            end
          end
        end
        default: begin
          if (count_done(int'(bit_ticks))) phase = PhIdle;
        end
      endcase
      last_lvl = level;
      r.avail  = (rd_idx != wr_idx);
      r.ovf    = ovf;
      due.push_back(r);
    endfunction

    function void check_tick(byte_t got_data, logic got_valid, logic got_avail,
                             logic got_ovf);
      tick_result_t want;
      if (due.size() == 0) begin
        $display("%0t: result with none expected, read_data expected none actual %02h",
                 $time, got_data);
        errors++;
        return;
      end
      want = due.pop_front();
      if (got_data !== want.data) begin
        $display("%0t: read_data expected %02h actual %02h", $time, want.data, got_data);
        errors++;
      end
      if (got_valid !== want.valid) begin
        $display("%0t: read_valid expected %0b actual %0b", $time, want.valid, got_valid);
        errors++;
      end
      if (got_avail !== want.avail) begin
        $display("%0t: data_available expected %0b actual %0b", $time, want.avail,
                 got_avail);
        errors++;
      end
      if (got_ovf !== want.ovf) begin
        $display("%0t: overflow_seen expected %0b actual %0b", $time, want.ovf, got_ovf);
        errors++;
      end
    endfunction
  endclass

endpackage

// ===== tb/tb_top.sv =====
// top-level testbench for the serial receiver with receive buffer
`timescale 1ns / 1ps

module tb_top;
  import uartrx_pkg::*;
  import uart_rx_tracker_pkg::*;

  localparam int WatchdogLimit = 1000;

  logic             clk           = 1'b0;
  logic             rst_n         = 1'b0;
  logic             in_valid      = 1'b0;
  logic             in_stall;
  logic             rx_level      = 1'b1;
  logic             read_request  = 1'b0;
  logic             out_valid;
  logic             out_stall     = 1'b0;
  logic [DataW-1:0] read_data;
  logic             read_valid;
  logic             data_available;
  logic             overflow_seen;
  logic             cfg_valid     = 1'b0;
  logic             cfg_ready;
  logic [TickW-1:0] cfg_bit_ticks = '0;

  int             send_idle_pct  = 9;
  int             recv_stall_pct = 57;
  int             idle_cycles    = 0;
  rx_fifo_tracker trk;

  uart_receiver_with_fifo dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .rx_level_i       (rx_level),
    .read_request_i   (read_request),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .read_data_o      (read_data),
    .read_valid_o     (read_valid),
    .data_available_o (data_available),
    .overflow_seen_o  (overflow_seen),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_bit_ticks_i  (cfg_bit_ticks)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // result check and watchdog
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      trk.check_tick(read_data, read_valid, data_available, overflow_seen);
    end
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles = idle_cycles + 1;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic logic coin(int pct);
    return ($urandom_range(99) < pct);
  endfunction

  task automatic send_tick(logic level, logic req);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid     <= 1'b1;
    rx_level     <= level;
    read_request <= req;
    do @(posedge clk); while (in_stall);
    trk.note_tick(level, req);
  endtask

  // sender holds off until every result is back
  task automatic pause_input();
    @(negedge clk);
    in_valid <= 1'b0;
    while (trk.pending_count() != 0) @(posedge clk);
  endtask

  task automatic write_bit_ticks(logic [TickW-1:0] v);
    pause_input();
    repeat (2) @(posedge clk);
    @(negedge clk);
    cfg_valid     <= 1'b1;
    cfg_bit_ticks <= v;
    do @(posedge clk); while (!cfg_ready);
    trk.bit_ticks = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // start bit, 8 data bits lsb first, stop bit, then gap ticks of idle line
  task automatic send_frame(byte_t b, int bt, int gap, int req_pct, bit pop_on_store);
    int   half_t;
    int   bit_t;
    int   store_t;
    logic level;
    half_t  = (bt / 2 < 1) ? 1 : bt / 2;
    bit_t   = (bt < 1) ? 1 : bt;
    store_t = half_t + 8 * bit_t;
    for (int t = 0; t < store_t + bit_t + 1 + gap; t++) begin
      if (t <= half_t) begin
        level = 1'b0;
      end else if (t <= store_t) begin
        level = b[(t - half_t - 1) / bit_t];
      end else begin
        level = 1'b1;
      end
      send_tick(level, coin(req_pct) || (pop_on_store && t == store_t));
    end
  endtask

  task automatic send_mixed(int bt, int req_pct, int units);
    int roll;
    repeat (units) begin
      roll = $urandom_range(99);
      if (roll < 70) begin
        send_frame(byte_t'($urandom), bt, $urandom_range(3), req_pct, 1'b0);
      end else if (roll < 85) begin
        // truncated frame
        repeat (bt) send_tick(1'b0, coin(req_pct));
        repeat ($urandom_range(1, 8 * bt)) send_tick(1'($urandom_range(1)), coin(req_pct));
        repeat (bt) send_tick(1'b1, coin(req_pct));
      end else begin
        repeat ($urandom_range(1, 8)) send_tick(1'($urandom_range(1)), coin(req_pct));
      end
    end
  endtask

  initial begin
    int guard;
    trk = new();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    write_bit_ticks(16'd2);
    send_tick(1'b1, 1'b1);
    // byte stored on the tick of a pop from empty
    send_frame(8'h00, 2, 0, 0, 1'b1);
    send_tick(1'b1, 1'b1);
    send_tick(1'b1, 1'b1);

    // fill the buffer with no pops, one-tick bit time
    write_bit_ticks(16'd1);
    guard = 0;
    send_frame(8'hff, 1, 1, 0, 1'b0);
    while (trk.fill_level() < BufferDepth - 1 && guard < 80) begin
      send_frame(byte_t'($urandom), 1, $urandom_range(1), 0, 1'b0);
      guard++;
    end
    // pop frees a slot on the store tick, then the next byte is dropped
    send_frame(byte_t'($urandom), 1, 0, 0, 1'b1);
    send_frame(byte_t'($urandom), 1, 1, 0, 1'b0);
    repeat (4) send_frame(byte_t'($urandom), 1, 0, 85, 1'b0);
    write_bit_ticks(16'd2);
    send_mixed(2, 30, 4);

    send_idle_pct  = 57;
    recv_stall_pct = 9;
    write_bit_ticks(16'hffff);
    repeat (40) send_tick(1'($urandom_range(1)), coin(50));
    write_bit_ticks(16'd3);
    send_mixed(3, 40, 2);
    pause_input();
    send_mixed(3, 40, 2);

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    write_bit_ticks(16'd5);
    send_mixed(5, 35, 1);

    pause_input();
    repeat (10) @(posedge clk);
    if (trk.errors == 0 && trk.pending_count() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== uart_receiver_with_fifo.f =====
+incdir+rtl/core
rtl/core/uartrx_pkg.sv
rtl/core/uartrx_ring.sv
rtl/core/uart_receiver_with_fifo.sv
tb/uart_rx_tracker_pkg.sv
tb/tb_top.sv
